@@ hw/rtl/mer_pkg.sv @@
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

   // Field and term widths
   localparam int COORD_W  = 16;
   localparam int RIN_W    = 13;
   localparam int RADIUS_W = 12;
   localparam int YPOS_W   = 13;
   localparam int SQ_W     = 2 * RADIUS_W;
   localparam int PROD_W   = SQ_W + RADIUS_W;
   localparam int SLOPE_W  = 40;
   localparam int TERM_W   = 48;
   localparam int COLOR_W  = 24;

   // Drawing phase
   typedef enum logic [1:0] {
      PH_REGION1 = 2'd0,
      PH_REGION2 = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   // Datapath operation for one cycle
   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_SQUARE,
      OP_PRODUCT,
      OP_SETUP,
      OP_REGION1,
      OP_REGION2,
      OP_HORZ
   } op_type;

   // Command bundle from the controller to the datapath
   typedef struct packed {
      op_type     op;
      logic       out_load;
      logic       out_empty;
      logic [1:0] out_index;
      logic       out_done;
   } cmd_type;

   // Status bundle from the datapath to the controller
   typedef struct packed {
      logic slope_gt;
      logic x_nonzero;
   } status_type;

endpackage

@@ hw/rtl/mer_ctrl.sv @@
// Controller state machine that sequences set-up, iterations and pixel output.
module mer_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_func,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  mer_pkg::status_type status,
   output mer_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_PRODUCT,
      S_SETUP,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   mer_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         index_ff, index_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT);

   // Next state, phase and datapath commands.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      index_in      = index_ff;
      cmd.op        = mer_pkg::OP_NONE;
      cmd.out_load  = 1'b0;
      cmd.out_empty = 1'b0;
      cmd.out_index = 2'd0;
      cmd.out_done  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (!req_func) begin
                  cmd.op   = mer_pkg::OP_START;
                  state_in = S_SQUARE;
               end else if (phase_ff == mer_pkg::PH_REGION1) begin
                  cmd.op   = mer_pkg::OP_REGION1;
                  state_in = S_CHECK;
               end else if (phase_ff == mer_pkg::PH_REGION2) begin
                  cmd.op   = mer_pkg::OP_REGION2;
                  state_in = S_CHECK;
               end else begin
                  // Drawing has finished: a single result without a pixel.
                  cmd.out_load  = 1'b1;
                  cmd.out_empty = 1'b1;
                  index_in      = 2'd3;
                  state_in      = S_EMIT;
               end
            end
         end
         S_SQUARE: begin
            cmd.op   = mer_pkg::OP_SQUARE;
            state_in = S_PRODUCT;
         end
         S_PRODUCT: begin
            cmd.op   = mer_pkg::OP_PRODUCT;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.op   = mer_pkg::OP_SETUP;
            phase_in = mer_pkg::PH_REGION1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // Decide what follows, then present the first mirrored pixel.
            if (phase_ff == mer_pkg::PH_REGION1 && status.slope_gt) begin
               phase_in = mer_pkg::PH_REGION1;
            end else begin
               if (phase_ff == mer_pkg::PH_REGION1) begin
                  cmd.op = mer_pkg::OP_HORZ;
               end
               phase_in = status.x_nonzero ? mer_pkg::PH_REGION2 : mer_pkg::PH_DONE;
            end
            cmd.out_load = 1'b1;
            index_in     = 2'd0;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (index_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  index_in      = index_ff + 2'd1;
                  cmd.out_load  = 1'b1;
                  cmd.out_index = index_ff + 2'd1;
                  cmd.out_done  = (index_ff == 2'd2) && (phase_ff == mer_pkg::PH_DONE);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, phase and pixel index registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= mer_pkg::PH_DONE;
         index_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

endmodule

@@ hw/rtl/mer_dpath.sv @@
// Datapath holding the ellipse terms, their updates and the result register.
module mer_dpath (
   input  logic                                clock,
   input  mer_pkg::cmd_type                    cmd,
   input  logic signed [mer_pkg::COORD_W-1:0]  center_x,
   input  logic signed [mer_pkg::COORD_W-1:0]  center_y,
   input  logic signed [mer_pkg::RIN_W-1:0]    radius_a,
   input  logic signed [mer_pkg::RIN_W-1:0]    radius_b,
   input  logic        [mer_pkg::COLOR_W-1:0]  pen_color,
   output mer_pkg::status_type                 status,
   output logic signed [mer_pkg::COORD_W-1:0]  pixel_x,
   output logic signed [mer_pkg::COORD_W-1:0]  pixel_y,
   output logic        [mer_pkg::COLOR_W-1:0]  pixel_color,
   output logic                                has_pixel,
   output logic                                last_of_run,
   output logic                                done_res
);

   localparam int TW = mer_pkg::TERM_W;
   localparam int SW = mer_pkg::SLOPE_W;

   logic        [mer_pkg::RADIUS_W-1:0] cur_x_ff, cur_x_in;
   logic signed [mer_pkg::YPOS_W-1:0]   cur_y_ff, cur_y_in;
   logic        [mer_pkg::RADIUS_W-1:0] rad_b_ff, rad_b_in;
   logic        [mer_pkg::SQ_W-1:0]     a_sq_ff, a_sq_in;
   logic        [mer_pkg::SQ_W-1:0]     b_sq_ff, b_sq_in;
   logic        [mer_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [TW-1:0]                decision_ff, decision_in;
   logic signed [TW-1:0]                step_horz_ff, step_horz_in;
   logic signed [TW-1:0]                step_vert_ff, step_vert_in;
   logic signed [TW-1:0]                step_diag_ff, step_diag_in;
   logic signed [SW-1:0]                slope_x_ff, slope_x_in;
   logic signed [SW-1:0]                slope_y_ff, slope_y_in;
   logic signed [mer_pkg::COORD_W-1:0]  centre_col_ff, centre_col_in;
   logic signed [mer_pkg::COORD_W-1:0]  centre_row_ff, centre_row_in;
   logic        [mer_pkg::COLOR_W-1:0]  color_ff, color_in;

   logic signed [mer_pkg::COORD_W-1:0]  pix_x_ff, pix_y_ff;
   logic        [mer_pkg::COLOR_W-1:0]  pix_color_ff;
   logic                                has_pixel_ff, last_ff, done_ff;

   logic [mer_pkg::RIN_W-1:0]    mag_a, mag_b;
   logic [mer_pkg::RADIUS_W-1:0] sat_a, sat_b;
   logic [TW-1:0]                a_sq_w, b_sq_w, a2_w, b2_w, sum2_w;
   logic [TW-1:0]                init_w, a3_w, dec_sum_w, slope_x_w;
   logic [mer_pkg::COORD_W-1:0]  x_ext, y_ext, mir_x, mir_y;

   // Radius magnitudes, saturated to the radius range.
   always_comb begin
      mag_a = radius_a[mer_pkg::RIN_W-1] ? -radius_a : radius_a;
      mag_b = radius_b[mer_pkg::RIN_W-1] ? -radius_b : radius_b;
      sat_a = mag_a[mer_pkg::RIN_W-1] ? '1 : mag_a[mer_pkg::RADIUS_W-1:0];
      sat_b = mag_b[mer_pkg::RIN_W-1] ? '1 : mag_b[mer_pkg::RADIUS_W-1:0];
   end

   // Widened terms shared by the set-up and iteration updates.
   always_comb begin
      a_sq_w    = TW'(a_sq_ff);
      b_sq_w    = TW'(b_sq_ff);
      a2_w      = a_sq_w << 1;
      b2_w      = b_sq_w << 1;
      sum2_w    = a2_w + b2_w;
      init_w    = '0 - (TW'(prod_ff) << 1);
      a3_w      = a_sq_w + a2_w;
      dec_sum_w = init_w + a3_w;
      slope_x_w = TW'(slope_x_ff);
   end

   assign status.slope_gt  = (slope_x_ff > slope_y_ff);
   assign status.x_nonzero = (cur_x_ff != '0);

   // Term updates selected by the command.
   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      rad_b_in      = rad_b_ff;
      a_sq_in       = a_sq_ff;
      b_sq_in       = b_sq_ff;
      prod_in       = prod_ff;
      decision_in   = decision_ff;
      step_horz_in  = step_horz_ff;
      step_vert_in  = step_vert_ff;
      step_diag_in  = step_diag_ff;
      slope_x_in    = slope_x_ff;
      slope_y_in    = slope_y_ff;
      centre_col_in = centre_col_ff;
      centre_row_in = centre_row_ff;
      color_in      = color_ff;
      unique case (cmd.op)
         mer_pkg::OP_START: begin
            centre_col_in = center_x;
            centre_row_in = center_y;
            color_in      = pen_color;
            cur_x_in      = sat_a;
            rad_b_in      = sat_b;
            cur_y_in      = '0;
            slope_y_in    = '0;
            step_horz_in  = '0;
         end
         mer_pkg::OP_SQUARE: begin
            a_sq_in = mer_pkg::SQ_W'(cur_x_ff) * mer_pkg::SQ_W'(cur_x_ff);
            b_sq_in = mer_pkg::SQ_W'(rad_b_ff) * mer_pkg::SQ_W'(rad_b_ff);
         end
         mer_pkg::OP_PRODUCT: begin
            prod_in = mer_pkg::PROD_W'(b_sq_ff) * mer_pkg::PROD_W'(cur_x_ff);
         end
         mer_pkg::OP_SETUP: begin
            slope_x_in   = SW'(prod_ff);
            decision_in  = {{2{dec_sum_w[TW-1]}}, dec_sum_w[TW-1:2]};
            step_vert_in = a3_w;
            step_diag_in = init_w + b_sq_w + a2_w;
         end
         mer_pkg::OP_REGION1: begin
            if (!decision_ff[TW-1] && decision_ff != '0) begin
               cur_x_in     = cur_x_ff - 1'b1;
               slope_x_in   = slope_x_ff - SW'(b_sq_ff);
               decision_in  = decision_ff + step_diag_ff;
               step_diag_in = step_diag_ff + sum2_w;
            end else begin
               decision_in  = decision_ff + step_vert_ff;
               step_diag_in = step_diag_ff + a2_w;
            end
            step_vert_in = step_vert_ff + a2_w;
            cur_y_in     = cur_y_ff - 1'b1;
            slope_y_in   = slope_y_ff + SW'(a_sq_ff);
         end
         mer_pkg::OP_REGION2: begin
            cur_x_in = cur_x_ff - 1'b1;
            if (decision_ff[TW-1]) begin
               cur_y_in     = cur_y_ff - 1'b1;
               decision_in  = decision_ff + step_diag_ff;
               step_diag_in = step_diag_ff + sum2_w;
            end else begin
               decision_in  = decision_ff + step_horz_ff;
               step_diag_in = step_diag_ff + b2_w;
            end
            step_horz_in = step_horz_ff + b2_w;
         end
         mer_pkg::OP_HORZ: begin
            // b^2 * (1 - 2x), with b^2 * x already held as the slope term.
            step_horz_in = b_sq_w - ({{(TW-SW){slope_x_w[SW-1]}}, slope_x_w[SW-1:0]} << 1);
         end
         default: ;
      endcase
   end

   // Mirrored pixel for the requested index.
   always_comb begin
      x_ext = mer_pkg::COORD_W'(cur_x_ff);
      y_ext = {{(mer_pkg::COORD_W-mer_pkg::YPOS_W){cur_y_ff[mer_pkg::YPOS_W-1]}}, cur_y_ff};
      mir_x = cmd.out_index[0] ? centre_col_ff - x_ext : centre_col_ff + x_ext;
      mir_y = cmd.out_index[1] ? centre_row_ff - y_ext : centre_row_ff + y_ext;
   end

   // Term registers.
   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      rad_b_ff      <= rad_b_in;
      a_sq_ff       <= a_sq_in;
      b_sq_ff       <= b_sq_in;
      prod_ff       <= prod_in;
      decision_ff   <= decision_in;
      step_horz_ff  <= step_horz_in;
      step_vert_ff  <= step_vert_in;
      step_diag_ff  <= step_diag_in;
      slope_x_ff    <= slope_x_in;
      slope_y_ff    <= slope_y_in;
      centre_col_ff <= centre_col_in;
      centre_row_ff <= centre_row_in;
      color_ff      <= color_in;
   end

   // Result register, loaded for each transaction on the result channel.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_empty) begin
            pix_x_ff     <= '0;
            pix_y_ff     <= '0;
            pix_color_ff <= '0;
            has_pixel_ff <= 1'b0;
            last_ff      <= 1'b1;
            done_ff      <= 1'b1;
         end else begin
            pix_x_ff     <= mir_x;
            pix_y_ff     <= mir_y;
            pix_color_ff <= color_ff;
            has_pixel_ff <= 1'b1;
            last_ff      <= (cmd.out_index == 2'd3);
            done_ff      <= cmd.out_done;
         end
      end
   end

   assign pixel_x     = pix_x_ff;
   assign pixel_y     = pix_y_ff;
   assign pixel_color = pix_color_ff;
   assign has_pixel   = has_pixel_ff;
   assign last_of_run = last_ff;
   assign done_res    = done_ff;

endmodule

@@ hw/rtl/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: ports, field packing, controller and datapath.
//
//  Channel  Direction  Payload
//  req_*    in         tuser: func; tdata: centre, radii, colour
//  rsp_*    out        tdata: pixel position and colour; tuser: flags; tlast: last of run
//
// A start transaction runs through accept, squaring, product, set-up and region check,
// then four results. A step runs through accept and check, then four results; a step
// after completion gives a single empty result. The multiplier steps make a start longer.
// Reset leaves the block idle with drawing finished. A stalled result channel holds the
// result register and the controller until the transaction completes.
module midpoint_ellipse_rasterizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] center_x, [31:16] center_y, [44:32] radius_a, [57:45] radius_b,
   // [81:58] pen_color, [87:82] zero
   input  logic [87:0] req_tdata,
   // [0] func
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] pixel_x, [31:16] pixel_y, [55:32] pixel_color
   output logic [55:0] rsp_tdata,
   // [0] has_pixel, [1] done_res
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   mer_pkg::cmd_type    cmd;
   mer_pkg::status_type status;

   logic signed [mer_pkg::COORD_W-1:0] pixel_x, pixel_y;
   logic        [mer_pkg::COLOR_W-1:0] pixel_color;
   logic                               has_pixel, done_res;

   mer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mer_dpath u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .center_x    (req_tdata[15:0]),
      .center_y    (req_tdata[31:16]),
      .radius_a    (req_tdata[44:32]),
      .radius_b    (req_tdata[57:45]),
      .pen_color   (req_tdata[81:58]),
      .status      (status),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .has_pixel   (has_pixel),
      .last_of_run (rsp_tlast),
      .done_res    (done_res)
   );

   // Pack the result fields.
   assign rsp_tdata = {pixel_color, pixel_y, pixel_x};
   assign rsp_tuser = {done_res, has_pixel};

endmodule

@@ tb/midpoint_ellipse_rasterizer_tb.sv @@
// Self-checking testbench for the midpoint ellipse rasterizer with its own outline predictor.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;

   // Operation carried in tuser of the request channel.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int PHASE_ITEMS    = 96;

   // One request transaction: func, then the fields of tdata from its lowest bit up.
   typedef struct packed {
      logic               func;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [12:0] radius_a;
      logic signed [12:0] radius_b;
      logic [23:0]        pen_color;
   } draw_req_type;

   // One response transaction.
   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [23:0] pixel_color;
      logic        has_pixel;
      logic        last_of_run;
      logic        done_res;
   } pixel_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Stimulus and scoreboard bookkeeping.
   draw_req_type  draw_cmds[$];
   pixel_rsp_type pending_pixels[$];
   draw_req_type  on_bus;
   pixel_rsp_type got_pixel;
   pixel_rsp_type want_pixel;
   int            cmds_queued    = 0;
   int            cmds_accepted  = 0;
   int            mismatches     = 0;
   int            quiet_cycles   = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;

   // Predictor state of the outline walk.
   logic [11:0]        walk_x        = '0;
   logic signed [12:0] walk_y        = '0;
   logic signed [47:0] decision_term = '0;
   logic signed [47:0] horz_step     = '0;
   logic signed [47:0] vert_step     = '0;
   logic signed [47:0] diag_step     = '0;
   logic signed [39:0] slope_x       = '0;
   logic signed [39:0] slope_y       = '0;
   logic [23:0]        a_sq          = '0;
   logic [23:0]        b_sq          = '0;
   logic signed [15:0] origin_x      = '0;
   logic signed [15:0] origin_y      = '0;
   logic [23:0]        ink           = '0;
   mer_pkg::phase_type draw_phase    = mer_pkg::PH_DONE;

   midpoint_ellipse_rasterizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Magnitude of a semi-axis, saturated to the largest radius the block keeps.
   function automatic logic [11:0] radius_size(input logic signed [12:0] raw);
      int mag;
      mag = (raw < 0) ? -int'(raw) : int'(raw);
      if (mag > 4095) mag = 4095;
      return 12'(mag);
   endfunction

   // Leave region one once the slope has turned, and set up the horizontal term.
   task automatic leave_region_one();
      if (slope_x > slope_y) begin
         draw_phase = mer_pkg::PH_REGION1;
      end else begin
         horz_step  = 48'(longint'(b_sq) * (64'sd1 - 64'sd2 * longint'(walk_x)));
         draw_phase = (walk_x != 0) ? mer_pkg::PH_REGION2 : mer_pkg::PH_DONE;
      end
   endtask

   // Queue the four mirrored pixels of the current point.
   task automatic push_point(input logic done);
      pixel_rsp_type pix;
      for (int k = 0; k < 4; k++) begin
         pix.pixel_x     = ((k & 1) != 0) ? origin_x - 16'(walk_x) : origin_x + 16'(walk_x);
         pix.pixel_y     = ((k & 2) != 0) ? origin_y - 16'(walk_y) : origin_y + 16'(walk_y);
         pix.pixel_color = ink;
         pix.has_pixel   = 1'b1;
         pix.last_of_run = (k == 3);
         pix.done_res    = (k == 3) && done;
         pending_pixels.push_back(pix);
      end
   endtask

   // Advance the outline walk by one accepted request and queue the pixels it causes.
   task automatic trace_outline(input draw_req_type cmd);
      logic [11:0]   ma;
      logic [11:0]   mb;
      longint        init;
      longint        a2;
      longint        b2;
      longint        sum2;
      pixel_rsp_type empty;
      a2   = 2 * longint'(a_sq);
      b2   = 2 * longint'(b_sq);
      sum2 = a2 + b2;
      if (cmd.func == FUNC_START) begin
         // A new ellipse: latch the geometry and emit the point on the horizontal axis.
         ma            = radius_size(cmd.radius_a);
         mb            = radius_size(cmd.radius_b);
         origin_x      = cmd.center_x;
         origin_y      = cmd.center_y;
         ink           = cmd.pen_color;
         walk_x        = ma;
         walk_y        = '0;
         a_sq          = 24'(longint'(ma) * longint'(ma));
         b_sq          = 24'(longint'(mb) * longint'(mb));
         slope_x       = 40'(longint'(b_sq) * longint'(walk_x));
         slope_y       = '0;
         init          = -2 * longint'(b_sq) * longint'(walk_x);
         decision_term = 48'((init + 3 * longint'(a_sq)) >>> 2);
         vert_step     = 48'(3 * longint'(a_sq));
         diag_step     = 48'(init + longint'(b_sq) + 2 * longint'(a_sq));
         horz_step     = '0;
         leave_region_one();
         push_point(draw_phase == mer_pkg::PH_DONE);
      end else if (draw_phase == mer_pkg::PH_REGION1) begin
         // Region one: every iteration moves one row, diagonally when the decision is positive.
         if (decision_term > 0) begin
            walk_x        = walk_x - 12'd1;
            slope_x       = slope_x - 40'(longint'(b_sq));
            decision_term = decision_term + diag_step;
            diag_step     = diag_step + 48'(sum2);
            vert_step     = vert_step + 48'(a2);
         end else begin
            decision_term = decision_term + vert_step;
            vert_step     = vert_step + 48'(a2);
            diag_step     = diag_step + 48'(a2);
         end
         walk_y  = walk_y - 13'sd1;
         slope_y = slope_y + 40'(longint'(a_sq));
         leave_region_one();
         push_point(draw_phase == mer_pkg::PH_DONE);
      end else if (draw_phase == mer_pkg::PH_REGION2) begin
         // Region two: every iteration moves one column, diagonally when the decision is negative.
         walk_x = walk_x - 12'd1;
         if (decision_term < 0) begin
            walk_y        = walk_y - 13'sd1;
            decision_term = decision_term + diag_step;
            diag_step     = diag_step + 48'(sum2);
            horz_step     = horz_step + 48'(b2);
         end else begin
            decision_term = decision_term + horz_step;
            horz_step     = horz_step + 48'(b2);
            diag_step     = diag_step + 48'(b2);
         end
         draw_phase = (walk_x != 0) ? mer_pkg::PH_REGION2 : mer_pkg::PH_DONE;
         push_point(draw_phase == mer_pkg::PH_DONE);
      end else begin
         // Drawing has finished: a single empty result.
         empty             = '0;
         empty.last_of_run = 1'b1;
         empty.done_res    = 1'b1;
         pending_pixels.push_back(empty);
      end
   endtask

   function automatic draw_req_type start_cmd(input logic signed [15:0] cx,
                                              input logic signed [15:0] cy,
                                              input logic signed [12:0] ra,
                                              input logic signed [12:0] rb,
                                              input logic [23:0] col);
      draw_req_type c;
      c.func      = FUNC_START;
      c.center_x  = cx;
      c.center_y  = cy;
      c.radius_a  = ra;
      c.radius_b  = rb;
      c.pen_color = col;
      return c;
   endfunction

   // A step carries random content in the fields that it ignores.
   function automatic draw_req_type step_cmd();
      draw_req_type c;
      c           = start_cmd(16'($urandom), 16'($urandom), 13'($urandom), 13'($urandom),
                              24'($urandom));
      c.func      = FUNC_STEP;
      return c;
   endfunction

   task automatic send(input draw_req_type c);
      draw_cmds.push_back(c);
      cmds_queued++;
   endtask

   function automatic logic signed [12:0] small_radius();
      int mag;
      mag = $urandom_range(0, 14);
      return 13'(($urandom_range(1) != 0) ? -mag : mag);
   endfunction

   // Ellipses with random geometry, each followed by a random number of steps, plus stray steps.
   task automatic add_random_items(input int count);
      int                 made;
      int                 roll;
      int                 steps;
      logic signed [12:0] ra;
      logic signed [12:0] rb;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            send(step_cmd());
            made++;
         end else begin
            if (roll < 16) begin
               ra    = 13'($urandom);
               rb    = 13'($urandom);
               steps = $urandom_range(0, 6);
            end else begin
               ra    = small_radius();
               rb    = small_radius();
               steps = $urandom_range(0, int'(radius_size(ra)) + int'(radius_size(rb)) + 3);
            end
            send(start_cmd(16'($urandom), 16'($urandom), ra, rb, 24'($urandom)));
            made++;
            repeat (steps) begin
               send(step_cmd());
               made++;
            end
         end
      end
   endtask

   // Hold back new requests until every queued request has been taken and answered.
   task automatic wait_drained();
      while (cmds_accepted != cmds_queued || pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string label, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Request driver: present queued transactions and predict each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            trace_outline(on_bus);
            cmds_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (draw_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus     = draw_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, on_bus.pen_color, on_bus.radius_b, on_bus.radius_a,
                              on_bus.center_y, on_bus.center_x};
               req_tuser  <= on_bus.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transaction with the oldest predicted pixel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_pixel.pixel_x     = rsp_tdata[15:0];
            got_pixel.pixel_y     = rsp_tdata[31:16];
            got_pixel.pixel_color = rsp_tdata[55:32];
            got_pixel.has_pixel   = rsp_tuser[0];
            got_pixel.done_res    = rsp_tuser[1];
            got_pixel.last_of_run = rsp_tlast;
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got_pixel);
               mismatches++;
            end else begin
               want_pixel = pending_pixels.pop_front();
               check_field("pixel_x", 24'(want_pixel.pixel_x), 24'(got_pixel.pixel_x));
               check_field("pixel_y", 24'(want_pixel.pixel_y), 24'(got_pixel.pixel_y));
               check_field("pixel_color", want_pixel.pixel_color, got_pixel.pixel_color);
               check_field("has_pixel", 24'(want_pixel.has_pixel), 24'(got_pixel.has_pixel));
               check_field("last_of_run", 24'(want_pixel.last_of_run),
                           24'(got_pixel.last_of_run));
               check_field("done_res", 24'(want_pixel.done_res), 24'(got_pixel.done_res));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: give up when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time,
                  pending_pixels.size());
         $display("midpoint_ellipse_rasterizer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus sequence: directed cases, then random traffic under several idling patterns.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Step straight after reset, then a small ellipse walked past its end.
      send(step_cmd());
      send(start_cmd(16'sd0, 16'sd0, 13'sd3, 13'sd2, 24'hFFFFFF));
      repeat (7) send(step_cmd());
      // Zero horizontal radius completes on the start itself.
      send(start_cmd(16'sd100, -16'sd50, 13'sd0, 13'sd5, 24'h123456));
      send(step_cmd());
      // Saturating radius and coordinates wrapping at both ends.
      send(start_cmd(16'h7FFF, 16'h8000, 13'h1000, 13'sd4095, 24'h000000));
      send(step_cmd());
      // Zero vertical radius, abandoned by a fresh start with negative radii.
      send(start_cmd(16'h8000, 16'h7FFF, 13'sd5, 13'sd0, 24'hA5A5A5));
      repeat (3) send(step_cmd());
      send(start_cmd(-16'sd1, 16'sd1, -13'sd2, -13'sd3, 24'h00FF00));
      repeat (7) send(step_cmd());
      wait_drained();

      for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 82;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 82;
            end
            default: begin
               send_idle_pct  = 35;
               recv_stall_pct = 35;
            end
         endcase
         add_random_items(PHASE_ITEMS);
         // The sender stays quiet here until every predicted pixel has come back.
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("midpoint_ellipse_rasterizer regression: pass");
      end else begin
         $display("midpoint_ellipse_rasterizer regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/mer_pkg.sv
hw/rtl/mer_ctrl.sv
hw/rtl/mer_dpath.sv
hw/rtl/midpoint_ellipse_rasterizer.sv
tb/midpoint_ellipse_rasterizer_tb.sv
